>>> design/lmde_pkg.sv
`timescale 1ns / 1ps

package lmde_pkg;

  // Default sizes of the list memory and the histogram memory.
  localparam int unsigned ListCapacityDef = 64;
  localparam int unsigned KeyBinsDef      = 128;

  // Fixed field widths.
  localparam int unsigned KeyW  = 7;
  localparam int unsigned CntW  = 7;
  localparam int unsigned FuncW = 2;
  localparam int unsigned KindW = 2;

  // Operation codes of an input word.
  localparam logic [FuncW-1:0] FUNC_ADD  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_DEL  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_LIST = 2'd2;

  // Kinds of a result word.
  localparam logic [KindW-1:0] KIND_ELEM = 2'd0;
  localparam logic [KindW-1:0] KIND_DEL  = 2'd1;
  localparam logic [KindW-1:0] KIND_DROP = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [KeyW-1:0]  key;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [KeyW-1:0]  key_res;
    logic [CntW-1:0]  count;
    logic             last;
  } res_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CLEAR,
    ST_COUNT,
    ST_COMPACT,
    ST_REPORT,
    ST_EMIT
  } state_e;

  // Datapath operations issued by the controller each cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_CLR,
    OP_CNT,
    OP_CMP,
    OP_RPT,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic   load;
    logic   rewind;
    dp_op_e op;
  } dp_ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic pass_done;
  } dp_stat_t;

endpackage

>>> design/list_mode_delete_engine.sv
`timescale 1ns / 1ps

// Ordered key list, newest first, with a delete that removes every copy of
// the most frequent key. A word is taken when start_i is high and busy_o is
// low. A list sends one result word per cycle. A delete clears the histogram
// memory one bin per cycle, then runs counting and compaction passes that go
// through the list memory one entry per cycle. Each result word is shown on
// res_o for exactly one cycle with res_strobe_o high and must be taken then:
// the receiver has no way to hold results off.
module list_mode_delete_engine import lmde_pkg::*; #(
  parameter int unsigned ListCapacity = ListCapacityDef,
  parameter int unsigned KeyBins      = KeyBinsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  cmd_t cmd_i,
  output logic res_strobe_o,
  output res_t res_o
);

  dp_ctrl_t dp_ctrl;
  dp_stat_t dp_stat;

  lmde_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (cmd_i.func),
    .stat_i  (dp_stat),
    .ctrl_o  (dp_ctrl),
    .busy_o  (busy_o)
  );

  lmde_dp #(
    .ListCapacity (ListCapacity),
    .KeyBins      (KeyBins)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .ctrl_i       (dp_ctrl),
    .stat_o       (dp_stat),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // A dropped add is reported only after an add word was taken, by way of the ADD state and the result register.
  a_drop_follows_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && (res_o.kind == KIND_DROP)) |->
      $past(start_i && !busy_o && (cmd_i.func == FUNC_ADD), 2))
    else $error("drop result without a preceding add");

  // A list run streams without gaps until its last word.
  a_list_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.last) |=> res_strobe_o)
    else $error("gap inside a list run");

  // The report step always yields exactly one final result word.
  a_report_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_ctrl.op == OP_RPT) |=>
      (res_strobe_o && res_o.last && (res_o.kind == KIND_DEL)))
    else $error("delete report missing");

  // No counting or compaction work goes on while the block is idle.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (dp_ctrl.op == OP_NONE))
    else $error("datapath operation while idle");

endmodule

>>> design/lmde_ctrl.sv
`timescale 1ns / 1ps

module lmde_ctrl import lmde_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [FuncW-1:0] func_i,
  input  dp_stat_t         stat_i,
  output dp_ctrl_t         ctrl_o,
  output logic             busy_o
);

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            FUNC_ADD:  state_d = ST_ADD;
            FUNC_DEL:  state_d = ST_CLEAR;
            FUNC_LIST: state_d = ST_EMIT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD:     state_d = ST_IDLE;
      ST_CLEAR:   if (stat_i.clr_last) state_d = ST_COUNT;
      ST_COUNT:   if (stat_i.pass_done) state_d = ST_COMPACT;
      ST_COMPACT: if (stat_i.pass_done) state_d = ST_REPORT;
      ST_REPORT:  state_d = ST_IDLE;
      ST_EMIT:    if (stat_i.pass_done) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctrl_o = '{load: 1'b0, rewind: 1'b0, op: OP_NONE};
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = start_i;
      end
      ST_ADD:   ctrl_o.op = OP_ADD;
      ST_CLEAR: ctrl_o.op = OP_CLR;
      ST_COUNT: begin
        ctrl_o.op     = OP_CNT;
        ctrl_o.rewind = stat_i.pass_done;
      end
      ST_COMPACT: ctrl_o.op = OP_CMP;
      ST_REPORT:  ctrl_o.op = OP_RPT;
      ST_EMIT:    ctrl_o.op = OP_EMIT;
      default:    ctrl_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/lmde_dp.sv
`timescale 1ns / 1ps

module lmde_dp import lmde_pkg::*; #(
  parameter int unsigned ListCapacity = ListCapacityDef,
  parameter int unsigned KeyBins      = KeyBinsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_t     cmd_i,
  input  dp_ctrl_t ctrl_i,
  output dp_stat_t stat_o,
  output logic     res_strobe_o,
  output res_t     res_o
);

  localparam int unsigned LaW  = (ListCapacity > 1) ? $clog2(ListCapacity) : 1;
  localparam int unsigned LenW = $clog2(ListCapacity + 1);
  localparam int unsigned HaW  = $clog2(KeyBins);

  // The list is a ring: logical entry i sits at head + i, wrapped once.
  function automatic logic [LaW-1:0] phys(input logic [LaW-1:0]  head,
                                          input logic [LenW-1:0] i);
    logic [LaW:0] sum;
    sum = {1'b0, head} + (LaW+1)'(i);
    if (sum >= (LaW+1)'(ListCapacity)) begin
      sum = sum - (LaW+1)'(ListCapacity);
    end
    return LaW'(sum);
  endfunction

  function automatic logic [HaW-1:0] bin_of(input logic [KeyW-1:0] k);
    return HaW'(k);
  endfunction

  // Key reduction table for histograms narrower than the key range.
  logic [KeyW-1:0] key_mod [1 << KeyW];
  for (genvar k = 0; k < (1 << KeyW); k++) begin : g_mod
    assign key_mod[k] = KeyW'(k % KeyBins);
  end

  // Memories and their ports.
  logic [KeyW-1:0] lst_mem [ListCapacity];
  logic [CntW-1:0] hst_mem [KeyBins];
  logic            lst_we, hst_we;
  logic [LaW-1:0]  lst_wa, lst_ra;
  logic [KeyW-1:0] lst_wd, lst_rd_q;
  logic [HaW-1:0]  hst_wa, hst_ra;
  logic [CntW-1:0] hst_wd, hst_rd_q;

  // Control registers.
  logic [LaW-1:0]  head_q, head_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [LenW-1:0] kept_q, kept_d;
  logic [HaW-1:0]  clr_q, clr_d;
  logic            s1_vld_q, s1_vld_d;
  logic            s2_vld_q, s2_vld_d;
  logic            byp_vld_q, byp_vld_d;
  logic            strobe_q, strobe_d;

  // Payload registers.
  logic [KeyW-1:0] key_q, key_d;
  logic            s1_last_q, s1_last_d;
  logic [KeyW-1:0] s2_key_q, s2_key_d;
  logic [KeyW-1:0] byp_key_q, byp_key_d;
  logic [CntW-1:0] byp_cnt_q, byp_cnt_d;
  logic [KeyW-1:0] best_key_q, best_key_d;
  logic [CntW-1:0] best_cnt_q, best_cnt_d;
  res_t            res_q, res_d;

  logic            issue;
  logic            full;
  logic [LaW-1:0]  head_dec;
  logic [CntW-1:0] cnt_cur, cnt_nxt;

  assign full     = (len_q == LenW'(ListCapacity));
  assign head_dec = (head_q == '0) ? LaW'(ListCapacity - 1) : head_q - LaW'(1);
  assign issue    = ((ctrl_i.op == OP_CNT) || (ctrl_i.op == OP_CMP) ||
                     (ctrl_i.op == OP_EMIT)) && (idx_q != len_q);

  // The bin written last cycle is not yet visible to this cycle's read data.
  assign cnt_cur = (byp_vld_q && (byp_key_q == s2_key_q)) ? byp_cnt_q : hst_rd_q;
  assign cnt_nxt = cnt_cur + CntW'(1);

  assign stat_o.clr_last  = (clr_q == HaW'(KeyBins - 1));
  assign stat_o.pass_done = (idx_q == len_q) && !s1_vld_q && !s2_vld_q;

  // Pass sequencing, histogram update and result formation.
  always_comb begin
    head_d     = head_q;
    len_d      = len_q;
    idx_d      = idx_q;
    kept_d     = kept_q;
    clr_d      = clr_q;
    key_d      = key_q;
    best_key_d = best_key_q;
    best_cnt_d = best_cnt_q;
    byp_key_d  = byp_key_q;
    byp_cnt_d  = byp_cnt_q;
    res_d      = res_q;
    strobe_d   = 1'b0;

    lst_we = 1'b0;
    lst_wa = phys(head_q, kept_q);
    lst_wd = lst_rd_q;
    lst_ra = phys(head_q, idx_q);
    hst_we = 1'b0;
    hst_wa = bin_of(s2_key_q);
    hst_wd = cnt_nxt;
    hst_ra = bin_of(lst_rd_q);

    // Read stage of the list memory.
    s1_vld_d  = issue;
    s1_last_d = ((idx_q + LenW'(1)) == len_q);
    if (issue) begin
      idx_d = idx_q + LenW'(1);
    end

    // Counting pipeline: list read, histogram read, increment and write.
    s2_vld_d  = s1_vld_q && (ctrl_i.op == OP_CNT);
    s2_key_d  = lst_rd_q;
    byp_vld_d = s2_vld_q;
    if (s2_vld_q) begin
      hst_we    = 1'b1;
      byp_key_d = s2_key_q;
      byp_cnt_d = cnt_nxt;
      if (cnt_nxt > best_cnt_q) begin
        best_cnt_d = cnt_nxt;
        best_key_d = s2_key_q;
      end
    end

    unique case (ctrl_i.op)
      OP_ADD: begin
        if (full) begin
          strobe_d = 1'b1;
          res_d    = '{kind: KIND_DROP, key_res: key_q, count: '0, last: 1'b1};
        end else begin
          lst_we = 1'b1;
          lst_wa = head_dec;
          lst_wd = key_mod[key_q];
          head_d = head_dec;
          len_d  = len_q + LenW'(1);
        end
      end
      OP_CLR: begin
        hst_we = 1'b1;
        hst_wa = clr_q;
        hst_wd = '0;
        clr_d  = clr_q + HaW'(1);
      end
      OP_CMP: begin
        if (s1_vld_q && (lst_rd_q != best_key_q)) begin
          lst_we = 1'b1;
          kept_d = kept_q + LenW'(1);
        end
      end
      OP_EMIT: begin
        if (s1_vld_q) begin
          strobe_d = 1'b1;
          res_d    = '{kind: KIND_ELEM, key_res: lst_rd_q, count: '0, last: s1_last_q};
        end
      end
      OP_RPT: begin
        strobe_d = 1'b1;
        res_d    = '{kind: KIND_DEL, key_res: best_key_q,
                     count: CntW'(len_q - kept_q), last: 1'b1};
        len_d    = kept_q;
      end
      default: begin
      end
    endcase

    // A new word or a new pass starts the counters over.
    if (ctrl_i.load || ctrl_i.rewind) begin
      idx_d    = '0;
      kept_d   = '0;
      s1_vld_d = 1'b0;
      s2_vld_d = 1'b0;
    end
    if (ctrl_i.load) begin
      key_d      = cmd_i.key;
      clr_d      = '0;
      best_key_d = '0;
      best_cnt_d = '0;
    end
  end

  // List memory.
  always_ff @(posedge clk_i) begin
    if (lst_we) begin
      lst_mem[lst_wa] <= lst_wd;
    end
    lst_rd_q <= lst_mem[lst_ra];
  end

  // Histogram memory.
  always_ff @(posedge clk_i) begin
    if (hst_we) begin
      hst_mem[hst_wa] <= hst_wd;
    end
    hst_rd_q <= hst_mem[hst_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      len_q     <= '0;
      idx_q     <= '0;
      kept_q    <= '0;
      clr_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      byp_vld_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      head_q    <= head_d;
      len_q     <= len_d;
      idx_q     <= idx_d;
      kept_q    <= kept_d;
      clr_q     <= clr_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      byp_vld_q <= byp_vld_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    s1_last_q  <= s1_last_d;
    s2_key_q   <= s2_key_d;
    byp_key_q  <= byp_key_d;
    byp_cnt_q  <= byp_cnt_d;
    best_key_q <= best_key_d;
    best_cnt_q <= best_cnt_d;
    res_q      <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule
